// ===== hdl/ppb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppb_pkg: shared definitions of the palette pixel blender
// Table sizes, draw mode and table select codes, and the packed RGB masks.
// ----------------------------------------------------------------------------
package ppb_pkg;

   localparam int PALETTE_SIZE       = 256;
   localparam int PAL_AW             = $clog2(PALETTE_SIZE);
   localparam int INVERSE_TABLE_SIZE = 32768;
   localparam int INV_AW             = $clog2(INVERSE_TABLE_SIZE);

   // Bound used to range check 8-bit palette indexes.
   localparam logic [8:0]  PAL_LIMIT       = 9'(PALETTE_SIZE);
   // Bound used to range check 15-bit table write indexes.
   localparam logic [14:0] PAL_INDEX_LIMIT = 15'(PALETTE_SIZE);

   // Draw modes.
   localparam logic [2:0] MODE_PLAIN             = 3'd0;
   localparam logic [2:0] MODE_TRANSLATE         = 3'd1;
   localparam logic [2:0] MODE_TRANSLUCENT       = 3'd2;
   localparam logic [2:0] MODE_TRANS_TRANSLUCENT = 3'd3;
   localparam logic [2:0] MODE_ADDITIVE          = 3'd4;
   localparam logic [2:0] MODE_ADD_TRANSLATE     = 3'd5;
   localparam logic [2:0] MODE_TRANS_LIGHT       = 3'd6;

   // Table selects of a table write transaction.
   localparam logic [2:0] SEL_TRANSLATE = 3'd0;
   localparam logic [2:0] SEL_LIGHT     = 3'd1;
   localparam logic [2:0] SEL_FORE_RGB  = 3'd2;
   localparam logic [2:0] SEL_BACK_RGB  = 3'd3;
   localparam logic [2:0] SEL_INVERSE   = 3'd4;

   // Actions.
   localparam logic ACT_DRAW  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Packed RGB guard and carry masks.
   localparam logic [31:0] TL_GUARD  = 32'h01f07c1f;
   localparam logic [31:0] ADD_GUARD = 32'h01f07c1f;
   localparam logic [31:0] ADD_CARRY = 32'h40100400;
   localparam logic [31:0] ADD_KEEP  = 32'h3fffffff;

endpackage

// ===== hdl/ppb_ram.sv =====
// ----------------------------------------------------------------------------
// ppb_ram: single-port table memory
// One access per cycle when enabled; write or read, read data registered.
// ----------------------------------------------------------------------------
module ppb_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wr_data;
         end
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/palette_pixel_blender_unit.sv =====
// ----------------------------------------------------------------------------
// palette_pixel_blender_unit: indexed frame buffer pixel shader
// Remaps or blends one texel with its background pixel per draw transaction;
// table write transactions load the five lookup tables.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   req_      in         req_valid/stall     action, texel, background, table_*
//   rsp_      out        rsp_valid/stall     pixel (draw transactions only)
//   csr_      in         csr_wr_en           draw mode, 3 bits
//
// One transaction is accepted per clock while req_stall is low. A draw
// result is presented through four register stages: translation read,
// RGB and light reads, blend, inverse colour read.
// Reset clears the valid bits and sets the draw mode to plain; tables hold
// whatever they held. A stalled result holds stage four only; empty stages
// behind it keep filling, so the input stalls only when all stages are full.
// Table writes happen in the stage where that table is read, so order holds.
// ----------------------------------------------------------------------------
module palette_pixel_blender_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_texel,
   input  logic [7:0]  req_background,
   input  logic [2:0]  req_table_select,
   input  logic [14:0] req_table_index,
   input  logic [31:0] req_table_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   localparam int PAW = ppb_pkg::PAL_AW;
   localparam int IAW = ppb_pkg::INV_AW;

   logic [2:0] mode_ff;

   // Stage load enables, chained back from the output.
   logic adv1, adv2, adv3, adv4;
   logic accept;

   // Stage 1
   logic        s1_valid_ff, s1_write_ff, s1_texel_ok_ff, s1_index_ok_ff;
   logic [7:0]  s1_texel_ff, s1_bg_ff;
   logic [2:0]  s1_sel_ff;
   logic [14:0] s1_index_ff;
   logic [31:0] s1_data_ff;
   logic [7:0]  trans_rd;

   // Stage 2
   logic        s2_valid_ff, s2_write_ff;
   logic        s2_fore_ok_ff, s2_back_ok_ff, s2_light_ok_ff;
   logic [7:0]  s2_texel_ff, s2_trans_ff;
   logic [2:0]  s2_sel_ff;
   logic [14:0] s2_index_ff;
   logic [7:0]  s2_data_ff;
   logic [31:0] fore_rd, back_rd;
   logic [7:0]  light_rd;

   // Stage 3
   logic          s3_valid_ff, s3_write_ff, s3_blend_ff;
   logic [2:0]    s3_sel_ff;
   logic [14:0]   s3_index_ff;
   logic [7:0]    s3_data_ff;
   logic [IAW-1:0] s3_inv_idx_ff;
   logic [7:0]    s3_px_ff;

   // Stage 4
   logic       s4_valid_ff, s4_blend_ff;
   logic [7:0] s4_px_ff;
   logic [7:0] inv_rd;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ppb_pkg::MODE_PLAIN;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Flow control
   // ------------------------------------------------------------------
   assign adv4      = !s4_valid_ff || !rsp_stall;
   assign adv3      = !s3_valid_ff || adv4;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;

   // ------------------------------------------------------------------
   // Stage 0 to 1: translation table access
   // ------------------------------------------------------------------
   logic req_index_ok;
   logic trans_we;

   assign req_index_ok = req_table_index < ppb_pkg::PAL_INDEX_LIMIT;
   assign trans_we     = (req_action == ppb_pkg::ACT_WRITE) && req_index_ok &&
                         (req_table_select == ppb_pkg::SEL_TRANSLATE);

   ppb_ram #(.DEPTH(ppb_pkg::PALETTE_SIZE), .WIDTH(8)) u_translate (
      .clock   (clock),
      .en      (accept),
      .we      (trans_we),
      .addr    ((req_action == ppb_pkg::ACT_WRITE) ? req_table_index[PAW-1:0]
                                                   : req_texel[PAW-1:0]),
      .wr_data (req_table_data[7:0]),
      .rd_data (trans_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_write_ff    <= req_action == ppb_pkg::ACT_WRITE;
         s1_texel_ok_ff <= {1'b0, req_texel} < ppb_pkg::PAL_LIMIT;
         s1_index_ok_ff <= req_index_ok;
         s1_texel_ff    <= req_texel;
         s1_bg_ff       <= req_background;
         s1_sel_ff      <= req_table_select;
         s1_index_ff    <= req_table_index;
         s1_data_ff     <= req_table_data;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 to 2: RGB and light table accesses
   // ------------------------------------------------------------------
   logic [7:0] trans_val, fore_idx;
   logic       use_trans_fore;
   logic       en2;
   logic       pal_we;

   // A texel beyond the palette translates to index zero.
   assign trans_val      = s1_texel_ok_ff ? trans_rd : 8'd0;
   assign use_trans_fore = (mode_ff == ppb_pkg::MODE_TRANS_TRANSLUCENT) ||
                           (mode_ff == ppb_pkg::MODE_ADD_TRANSLATE);
   assign fore_idx       = use_trans_fore ? trans_val : s1_texel_ff;
   assign en2            = adv2 && s1_valid_ff;
   assign pal_we         = s1_write_ff && s1_index_ok_ff;

   ppb_ram #(.DEPTH(ppb_pkg::PALETTE_SIZE), .WIDTH(32)) u_fore (
      .clock   (clock),
      .en      (en2),
      .we      (pal_we && (s1_sel_ff == ppb_pkg::SEL_FORE_RGB)),
      .addr    (s1_write_ff ? s1_index_ff[PAW-1:0] : fore_idx[PAW-1:0]),
      .wr_data (s1_data_ff),
      .rd_data (fore_rd)
   );

   ppb_ram #(.DEPTH(ppb_pkg::PALETTE_SIZE), .WIDTH(32)) u_back (
      .clock   (clock),
      .en      (en2),
      .we      (pal_we && (s1_sel_ff == ppb_pkg::SEL_BACK_RGB)),
      .addr    (s1_write_ff ? s1_index_ff[PAW-1:0] : s1_bg_ff[PAW-1:0]),
      .wr_data (s1_data_ff),
      .rd_data (back_rd)
   );

   ppb_ram #(.DEPTH(ppb_pkg::PALETTE_SIZE), .WIDTH(8)) u_light (
      .clock   (clock),
      .en      (en2),
      .we      (pal_we && (s1_sel_ff == ppb_pkg::SEL_LIGHT)),
      .addr    (s1_write_ff ? s1_index_ff[PAW-1:0] : trans_val[PAW-1:0]),
      .wr_data (s1_data_ff[7:0]),
      .rd_data (light_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_write_ff    <= s1_write_ff;
         s2_fore_ok_ff  <= {1'b0, fore_idx} < ppb_pkg::PAL_LIMIT;
         s2_back_ok_ff  <= {1'b0, s1_bg_ff} < ppb_pkg::PAL_LIMIT;
         s2_light_ok_ff <= {1'b0, trans_val} < ppb_pkg::PAL_LIMIT;
         s2_texel_ff    <= s1_texel_ff;
         s2_trans_ff    <= trans_val;
         s2_sel_ff      <= s1_sel_ff;
         s2_index_ff    <= s1_index_ff;
         s2_data_ff     <= s1_data_ff[7:0];
      end
   end

   // ------------------------------------------------------------------
   // Stage 2 to 3: blend arithmetic and direct pixel select
   // ------------------------------------------------------------------
   logic [31:0] fore_val, back_val, rgb_sum, tl_word, add_word, add_fill, blend_word;
   logic [7:0]  light_val;
   logic [7:0]  px_in;
   logic        blend_in, additive_in;

   assign fore_val  = s2_fore_ok_ff ? fore_rd : 32'd0;
   assign back_val  = s2_back_ok_ff ? back_rd : 32'd0;
   assign light_val = s2_light_ok_ff ? light_rd : 8'd0;
   assign rgb_sum   = fore_val + back_val;
   assign tl_word   = rgb_sum | ppb_pkg::TL_GUARD;

   // Each channel carry bit c at position k turns into c*(2^k - 2^(k-5)),
   // which fills the five bits below it; the carries are ten bits apart.
   always_comb begin
      add_fill        = 32'd0;
      add_fill[29:25] = {5{rgb_sum[30]}};
      add_fill[19:15] = {5{rgb_sum[20]}};
      add_fill[9:5]   = {5{rgb_sum[10]}};
   end

   assign add_word   = ((rgb_sum | ppb_pkg::ADD_GUARD) & ppb_pkg::ADD_KEEP) | add_fill;
   assign blend_word = additive_in ? add_word : tl_word;

   always_comb begin
      px_in       = s2_texel_ff;
      blend_in    = 1'b0;
      additive_in = 1'b0;
      unique case (mode_ff)
         ppb_pkg::MODE_TRANSLATE: begin
            px_in = s2_trans_ff;
         end
         ppb_pkg::MODE_TRANS_LIGHT: begin
            px_in = light_val;
         end
         ppb_pkg::MODE_TRANSLUCENT, ppb_pkg::MODE_TRANS_TRANSLUCENT: begin
            blend_in = 1'b1;
         end
         ppb_pkg::MODE_ADDITIVE, ppb_pkg::MODE_ADD_TRANSLATE: begin
            blend_in    = 1'b1;
            additive_in = 1'b1;
         end
         default: begin
            px_in = s2_texel_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_write_ff   <= s2_write_ff;
         s3_blend_ff   <= blend_in;
         s3_sel_ff     <= s2_sel_ff;
         s3_index_ff   <= s2_index_ff;
         s3_data_ff    <= s2_data_ff;
         s3_inv_idx_ff <= blend_word[IAW-1:0] & blend_word[IAW+14:15];
         s3_px_ff      <= px_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3 to 4: inverse colour table access
   // ------------------------------------------------------------------
   ppb_ram #(.DEPTH(ppb_pkg::INVERSE_TABLE_SIZE), .WIDTH(8)) u_inverse (
      .clock   (clock),
      .en      (adv4 && s3_valid_ff),
      .we      (s3_write_ff && (s3_sel_ff == ppb_pkg::SEL_INVERSE)),
      .addr    (s3_write_ff ? s3_index_ff[IAW-1:0] : s3_inv_idx_ff),
      .wr_data (s3_data_ff),
      .rd_data (inv_rd)
   );

   // Table write transactions end here and produce no result.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv4) begin
         s4_valid_ff <= s3_valid_ff && !s3_write_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_blend_ff <= s3_blend_ff;
         s4_px_ff    <= s3_px_ff;
      end
   end

   assign rsp_valid = s4_valid_ff;
   assign rsp_pixel = s4_blend_ff ? inv_rd : s4_px_ff;

endmodule

// ===== hdl/ppb_checker.sv =====
// ----------------------------------------------------------------------------
// ppb_checker: port level checks of the palette pixel blender
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module ppb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_pixel
);

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled result holds its pixel.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel))
      else $error("stalled response changed");

   // The input only stalls while a finished result is held at the output.
   a_no_needless_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while output is free");

   // With the output free and no requests, the pipeline drains and no result appears.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !req_valid) ##1 (!rsp_valid && !req_valid) ##1
      (!rsp_valid && !req_valid) ##1 (!rsp_valid && !req_valid) |=> !rsp_valid)
      else $error("response without an accepted draw transaction");

endmodule

bind palette_pixel_blender_unit ppb_checker u_ppb_checker (.*);
